/* rtl/bcsr_pkg.sv */
// Shared types and constants of the center-surround box response block.
package bcsr_pkg;

  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_SCALE  = 11;
  localparam int ROW_W      = 10;
  localparam int FIFO_DEPTH = 8;
  localparam int FP_W       = 3;

  localparam longint RESP_MAX = 64'sd16777215;
  localparam longint RESP_MIN = -64'sd16777216;

  typedef enum logic [2:0] {
    REG_SCALE   = 3'd0,
    REG_INNER_W = 3'd1,
    REG_OUTER_W = 3'd2,
    REG_WIDTH   = 3'd3,
    REG_HEIGHT  = 3'd4
  } cfg_reg_t;

  // Per-pixel tag that rides along with the arithmetic.
  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic       last;
  } ctx_t;

  typedef struct packed {
    logic [24:0] resp;
    ctx_t        ctx;
  } res_t;

endpackage

/* rtl/bcsr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bcsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bcsr_math.sv */
// Weighting pipeline: ring sum, split products, difference, floor shift, saturation.
module bcsr_math
  import bcsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [33:0] in_outer,
  input  logic signed [33:0] in_inner,
  input  ctx_t               in_ctx,
  input  logic [23:0]        center_gain,
  input  logic [23:0]        surround_gain,
  output logic               out_valid,
  output res_t               out_res
);

  logic [4:0] vld;
  ctx_t       ctx1, ctx2, ctx3, ctx4;

  logic signed [33:0] inner1;
  logic signed [34:0] ring1;
  logic signed [42:0] pi_lo, pr_lo, pr_hi;
  logic signed [41:0] pi_hi;
  logic signed [60:0] vi, vr, v;
  logic signed [52:0] q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: ring = outer - inner
    inner1 <= in_inner;
    ring1  <= 35'(in_outer) - 35'(in_inner);
    ctx1   <= in_ctx;
    // stage 2: 24-bit weight times low and high halves
    pi_lo  <= $signed({1'b0, center_gain}) * $signed({1'b0, inner1[16:0]});
    pi_hi  <= $signed({1'b0, center_gain}) * $signed(inner1[33:17]);
    pr_lo  <= $signed({1'b0, surround_gain}) * $signed({1'b0, ring1[16:0]});
    pr_hi  <= $signed({1'b0, surround_gain}) * $signed(ring1[34:17]);
    ctx2   <= ctx1;
    // stage 3: recombine halves
    vi     <= (61'(pi_hi) <<< 17) + 61'(pi_lo);
    vr     <= (61'(pr_hi) <<< 17) + 61'(pr_lo);
    ctx3   <= ctx2;
    // stage 4: center minus surround
    v      <= vi - vr;
    ctx4   <= ctx3;
    // stage 5: Q.20 -> Q.12, floor, clamp
    out_res.ctx <= ctx4;
    if (q > RESP_MAX) begin
      out_res.resp <= 25'h0FFFFFF;
    end else if (q < RESP_MIN) begin
      out_res.resp <= 25'h1000000;
    end else begin
      out_res.resp <= q[24:0];
    end
  end

  assign q         = v[60:8];
  assign out_valid = vld[4];

endmodule

/* rtl/box_center_surround_response.sv */
// Top level of the streamed center-surround box response block.
//
// Usage: integral-image words enter on s_* (one word per item, raster order,
// s_tuser marks the first word of a frame). For each word at (cx,cy) with
// cx >= 4n and cy >= 4n one result leaves on m_* for pixel (cx-2n, cy-2n);
// m_tlast marks the pixel of the frame's last word. Other words give nothing.
// Throughput: a result-producing word starts a sequence of seven row store
// reads spread over two RAM copies (four read slots each); s_tready is low
// until its last slot. Words that produce nothing are taken one per cycle
// outside such a sequence while fewer than 8 results are owed. A result passes
// the read slots, one sum stage, five weighting stages and the output queue.
// Stall: results queue in an 8-entry buffer; s_tready drops while 8 results
// are owed, so nothing is lost when m_tready is low.
// Reset: position counters return to column 0, row 0, registers take their
// default values; the row store is not cleared and needs no sweep.
// Config: cfg_we writes cfg_data to register cfg_index; only while idle.
module box_center_surround_response
  import bcsr_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int STORE_ROWS = 46
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] integral_value
  input  logic        s_tuser,   // [0] start_of_frame
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [24:0] response, [34:25] pixel_x, [44:35] pixel_y, pad
  output logic        m_tlast,   // last_of_frame
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int SLOT_W  = $clog2(STORE_ROWS);
  localparam int DEPTH   = STORE_ROWS * MAX_WIDTH;
  localparam int AW      = $clog2(DEPTH);
  localparam int LIM_RAW = (STORE_ROWS - 2) / 4;
  localparam int LIM     = LIM_RAW > MAX_SCALE ? MAX_SCALE : (LIM_RAW < 1 ? 1 : LIM_RAW);
  localparam int RST_W   = 640 > MAX_WIDTH ? MAX_WIDTH : 640;

  // ---------------- configuration ----------------
  logic [3:0]    n_eff;
  logic [23:0]   center_gain, surround_gain;
  logic [WW-1:0] w_eff;
  logic [10:0]   h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_eff         <= 4'd1;
      center_gain   <= 24'd1864135;
      surround_gain <= 24'd1048576;
      w_eff         <= WW'(RST_W);
      h_eff         <= 11'd480;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCALE: begin
          if (cfg_data[3:0] == 4'd0) n_eff <= 4'd1;
          else if (int'(cfg_data[3:0]) > LIM) n_eff <= 4'(LIM);
          else n_eff <= cfg_data[3:0];
        end
        REG_INNER_W: center_gain <= cfg_data;
        REG_OUTER_W: surround_gain <= cfg_data;
        REG_WIDTH: begin
          if (cfg_data[10:0] == 11'd0) w_eff <= WW'(1);
          else if (int'(cfg_data[10:0]) > MAX_WIDTH) w_eff <= WW'(MAX_WIDTH);
          else w_eff <= WW'(cfg_data[10:0]);
        end
        REG_HEIGHT: begin
          if (cfg_data[10:0] == 11'd0) h_eff <= 11'd1;
          else if (int'(cfg_data[10:0]) > MAX_HEIGHT) h_eff <= 11'(MAX_HEIGHT);
          else h_eff <= cfg_data[10:0];
        end
        default: ;
      endcase
    end
  end

  // corner offsets in rows and columns
  logic [5:0] k_n, k_2n, k_3n1, k_4n, k_4n1;
  assign k_n   = {2'b00, n_eff};
  assign k_2n  = {1'b0, n_eff, 1'b0};
  assign k_4n  = {n_eff, 2'b00};
  assign k_3n1 = k_2n + k_n + 6'd1;
  assign k_4n1 = k_4n + 6'd1;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(STORE_ROWS - 1)) ? '0 : s + 1'b1;
  endfunction

  // slot of the row k above the one held in slot s
  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s,
                                                  input logic [5:0] k);
    logic [SLOT_W+1:0] t;
    t = (SLOT_W+2)'(s) + (SLOT_W+2)'(STORE_ROWS) - (SLOT_W+2)'(k);
    if (t >= (SLOT_W+2)'(STORE_ROWS)) t = t - (SLOT_W+2)'(STORE_ROWS);
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [COL_W-1:0] col_back(input logic [COL_W-1:0] c,
                                                input logic [5:0] k);
    logic [15:0] t;
    t = 16'(c) - 16'(k);
    return t[COL_W-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [SLOT_W-1:0] s,
                                            input logic [COL_W-1:0] c);
    return AW'(s) * AW'(MAX_WIDTH) + AW'(c);
  endfunction

  // ---------------- raster position ----------------
  logic [COL_W-1:0]  col, c_a, c_nx;
  logic [ROW_W-1:0]  row, r_a;
  logic [ROW_W:0]    r_t, r_n;
  logic [SLOT_W-1:0] slot, s_a, s_n;
  logic [WW-1:0]     c_inc;

  always_comb begin
    c_a = s_tuser ? '0 : col;
    r_t = s_tuser ? '0 : {1'b0, row};
    s_a = s_tuser ? '0 : slot;
    if (WW'(c_a) >= w_eff) begin
      c_a = '0;
      r_t = r_t + 1'b1;
      s_a = slot_inc(s_a);
    end
    if (r_t >= h_eff) begin
      r_t = '0;
      s_a = '0;
    end
    r_a   = r_t[ROW_W-1:0];
    c_inc = WW'(c_a) + 1'b1;
    r_n   = {1'b0, r_a};
    s_n   = s_a;
    c_nx  = c_inc[COL_W-1:0];
    if (c_inc >= w_eff) begin
      c_nx = '0;
      r_n  = r_n + 1'b1;
      s_n  = slot_inc(s_n);
      if (r_n >= h_eff) begin
        r_n = '0;
        s_n = '0;
      end
    end
  end

  logic produce, accept, busy;
  logic [1:0] phase;
  logic [3:0] pending, fcount;

  assign produce  = (16'(c_a) >= 16'(k_4n)) && (16'(r_a) >= 16'(k_4n));
  assign s_tready = (!busy || phase == 2'd3) && (pending < 4'(FIFO_DEPTH));
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (accept) begin
      col  <= c_nx;
      row  <= r_n[ROW_W-1:0];
      slot <= s_n;
    end
  end

  // ---------------- read sequencer ----------------
  logic [COL_W-1:0]  q_cx, q_cin_hi, q_cin_lo, q_cout_lo;
  logic [SLOT_W-1:0] q_scur, q_sin_hi, q_sin_lo, q_sout_lo;
  logic [31:0]       q_o1;
  logic              q_zr, q_zc;
  ctx_t              q_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= '0;
    end else if (accept && produce) begin
      busy  <= 1'b1;
      phase <= '0;
    end else if (busy) begin
      busy  <= (phase != 2'd3);
      phase <= phase + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      q_cx      <= c_a;
      q_cin_hi  <= col_back(c_a, k_n);
      q_cin_lo  <= col_back(c_a, k_3n1);
      // column left of the outer box is off-image at the left edge
      q_cout_lo <= (16'(c_a) == 16'(k_4n)) ? '0 : col_back(c_a, k_4n1);
      q_scur    <= s_a;
      q_sin_hi  <= slot_back(s_a, k_n);
      q_sin_lo  <= slot_back(s_a, k_3n1);
      q_sout_lo <= slot_back(s_a, k_4n1);
      q_o1      <= s_tdata;
      q_zc      <= (16'(c_a) == 16'(k_4n));
      q_zr      <= (16'(r_a) == 16'(k_4n));
      q_ctx.x   <= 10'(16'(c_a) - 16'(k_2n));
      q_ctx.y   <= 10'(16'(r_a) - 16'(k_2n));
      q_ctx.last <= (WW'(c_a) == w_eff - 1'b1) && (11'(r_a) == h_eff - 1'b1);
    end
  end

  // port A: O2, O3, O4, I1; port B: I2, I3, I4
  logic [AW-1:0] raddr_a, raddr_b, waddr;
  logic [31:0]   rdata_a, rdata_b;

  always_comb begin
    case (phase)
      2'd0:    raddr_a = addr_of(q_sout_lo, q_cx);
      2'd1:    raddr_a = addr_of(q_scur, q_cout_lo);
      2'd2:    raddr_a = addr_of(q_sout_lo, q_cout_lo);
      default: raddr_a = addr_of(q_sin_hi, q_cin_hi);
    endcase
    case (phase)
      2'd0:    raddr_b = addr_of(q_sin_lo, q_cin_hi);
      2'd1:    raddr_b = addr_of(q_sin_hi, q_cin_lo);
      default: raddr_b = addr_of(q_sin_lo, q_cin_lo);
    endcase
  end

  assign waddr = addr_of(s_a, c_a);

  bcsr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (
    .clk(clk), .we(accept), .waddr(waddr), .wdata(s_tdata),
    .raddr(raddr_a), .rdata(rdata_a)
  );

  bcsr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_b (
    .clk(clk), .we(accept), .waddr(waddr), .wdata(s_tdata),
    .raddr(raddr_b), .rdata(rdata_b)
  );

  // ---------------- corner capture and box sums ----------------
  logic        rvld;
  logic [1:0]  rph;
  logic [31:0] o2, o3, o4, i2, i3, i4, c1_o1;
  logic        c1_zr, c1_zc;
  ctx_t        c1_ctx, s1_ctx;
  logic        s1_valid;
  logic signed [33:0] s1_outer, s1_inner;

  always_ff @(posedge clk) begin
    if (rst) begin
      rvld     <= 1'b0;
      rph      <= '0;
      s1_valid <= 1'b0;
    end else begin
      rvld     <= busy;
      rph      <= phase;
      s1_valid <= rvld && (rph == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    // context leaves the sequencer before the next item overwrites it
    if (busy && phase == 2'd3) begin
      c1_o1  <= q_o1;
      c1_zr  <= q_zr;
      c1_zc  <= q_zc;
      c1_ctx <= q_ctx;
    end
    if (rvld) begin
      case (rph)
        2'd0: begin
          o2 <= rdata_a;
          i2 <= rdata_b;
        end
        2'd1: begin
          o3 <= rdata_a;
          i3 <= rdata_b;
        end
        2'd2: begin
          o4 <= rdata_a;
          i4 <= rdata_b;
        end
        default: begin
          s1_outer <= $signed({2'b00, c1_o1})
                    - $signed({2'b00, c1_zr ? 32'd0 : o2})
                    - $signed({2'b00, c1_zc ? 32'd0 : o3})
                    + $signed({2'b00, (c1_zr || c1_zc) ? 32'd0 : o4});
          s1_inner <= $signed({2'b00, rdata_a}) - $signed({2'b00, i2})
                    - $signed({2'b00, i3}) + $signed({2'b00, i4});
          s1_ctx   <= c1_ctx;
        end
      endcase
    end
  end

  logic res_valid;
  res_t res;

  bcsr_math u_math (
    .clk(clk), .rst(rst),
    .in_valid(s1_valid), .in_outer(s1_outer), .in_inner(s1_inner), .in_ctx(s1_ctx),
    .center_gain(center_gain), .surround_gain(surround_gain),
    .out_valid(res_valid), .out_res(res)
  );

  // ---------------- output queue ----------------
  res_t            fifo [FIFO_DEPTH];
  logic [FP_W-1:0] wp, rp;
  logic            pop;
  res_t            head;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (fcount != 4'd0);
  assign head     = fifo[rp];
  assign m_tdata  = {3'b000, head.ctx.y, head.ctx.x, head.resp};
  assign m_tlast  = head.ctx.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      rp      <= '0;
      fcount  <= '0;
      pending <= '0;
    end else begin
      if (res_valid) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      fcount  <= fcount + 4'(res_valid) - 4'(pop);
      pending <= pending + 4'(accept && produce) - 4'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) fifo[wp] <= res;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (fcount < 4'(FIFO_DEPTH)))
    else $error("result queue overflow");

  a_credit: assert property (@(posedge clk) disable iff (rst)
    fcount <= pending)
    else $error("queued results exceed owed results");

  a_seq_start: assert property (@(posedge clk) disable iff (rst)
    (accept && produce) |=> (busy && phase == 2'd0))
    else $error("read sequencer did not start");

endmodule

/* verif/box_center_surround_response_tb.sv */
// Testbench for the streamed center-surround box response block.
module box_center_surround_response_tb
  import bcsr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 1024;
  localparam int ROWS  = 46;
  localparam int LIMIT = 20000;   // cycles with no item moving on either side

  typedef struct {
    logic [24:0] resp;
    logic [9:0]  px;
    logic [9:0]  py;
    logic        last;
  } pix_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  box_center_surround_response uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Own copy of the block's state and registers.
  logic [31:0] line_mem [ROWS*MAX_W];
  int unsigned col_pos, row_pos;
  int unsigned scale_reg, inner_w_reg, outer_w_reg, width_reg, height_reg;

  pix_result_t expected_q[$];
  int          errors;
  bit          src_idle_on = 1'b1;   // random source gaps
  bit          sink_idle_on = 1'b1;  // random sink stalls
  int          quiet_cycles = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint line_word(input int c, input int r);
    if (c < 0 || r < 0 || c >= MAX_W) return 0;
    return longint'(line_mem[(r % ROWS) * MAX_W + c]);
  endfunction

  function automatic longint box_total(input int x, input int y, input int h);
    return line_word(x + h, y + h) - line_word(x + h, y - h - 1)
         - line_word(x - h - 1, y + h) + line_word(x - h - 1, y - h - 1);
  endfunction

  // Advances the position and queues a response when the word closes a window.
  task automatic predict_word(input logic [31:0] val, input logic sof);
    int unsigned w, h, n, lim, cx, cy;
    int x, y;
    longint inner, ring, v, q;
    pix_result_t r;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_W ? MAX_W : width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
    lim = (ROWS - 2) / 4;
    if (lim > MAX_SCALE) lim = MAX_SCALE;
    n = (scale_reg == 0) ? 1 : (scale_reg > lim ? lim : scale_reg);
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    cx = col_pos;
    cy = row_pos;
    line_mem[(cy % ROWS) * MAX_W + cx] = val;
    if (cx >= 4 * n && cy >= 4 * n) begin
      x = cx - 2 * n;
      y = cy - 2 * n;
      inner = box_total(x, y, n);
      ring = box_total(x, y, 2 * n) - inner;
      v = longint'(inner_w_reg) * inner - longint'(outer_w_reg) * ring;
      q = v >>> 8;   // floor toward minus infinity
      if (q > RESP_MAX) q = RESP_MAX;
      if (q < RESP_MIN) q = RESP_MIN;
      r.resp = q[24:0];
      r.px = x[9:0];
      r.py = y[9:0];
      r.last = (cx == w - 1 && cy == h - 1);
      expected_q.push_back(r);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Sends one word; s_tvalid stays high across back-to-back items.
  task automatic send_word(input logic [31:0] val, input logic sof);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= val;
    s_tuser  <= sof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_word(val, sof);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SCALE:   scale_reg   = val & 32'hF;
      REG_INNER_W: inner_w_reg = val & 32'hFFFFFF;
      REG_OUTER_W: outer_w_reg = val & 32'hFFFFFF;
      REG_WIDTH:   width_reg   = val & 32'h7FF;
      REG_HEIGHT:  height_reg  = val & 32'h7FF;
      default: ;
    endcase
  endtask

  task automatic set_frame(input int unsigned n, input int unsigned w, input int unsigned h,
                           input int unsigned wi, input int unsigned wo);
    write_reg(REG_SCALE, n);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_INNER_W, wi);
    write_reg(REG_OUTER_W, wo);
  endtask

  // A whole frame of integral words; mode picks the value shape.
  task automatic send_frame(input int unsigned w, input int unsigned h, input int mode);
    logic [31:0] v;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        case (mode)
          0: v = (r + 1) * (c + 1) * $urandom_range(1, 300);
          1: v = $urandom();
          2: v = (r == 0 && c == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
          default: v = (r + 1) * (c + 1);
        endcase
        send_word(v, (r == 0 && c == 0));
      end
  endtask

  // Directed: extremes of value, weights and the smallest scale on 5x5 and 6x5 frames.
  task automatic test_directed();
    set_frame(1, 5, 5, 24'hFFFFFF, 0);
    send_frame(5, 5, 2);          // saturation high and full-range bits
    drain();
    set_frame(0, 6, 5, 0, 24'hFFFFFF);   // scale zero used as one, saturation low
    send_frame(6, 5, 2);
    drain();
  endtask

  // Too-small images and oversize scale produce no response.
  task automatic test_small_image();
    set_frame(15, 6, 6, 1864135, 1048576);     // scale clamps to 11
    send_frame(6, 6, 0);
    drain();
    set_frame(2, 8, 20, 1864135, 1048576);     // width equal to 4n
    send_frame(8, 4, 0);
    drain();
  endtask

  // Random frames, mostly well formed, with random weights and scales.
  task automatic test_random_frames();
    int unsigned n, w, h;
    for (int f = 0; f < 3; f++) begin
      n = $urandom_range(1, 2);
      w = $urandom_range(4 * n + 1, 4 * n + 4);
      h = $urandom_range(4 * n + 1, 4 * n + 2);
      set_frame(n, w, h, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
      send_frame(w, h, $urandom_range(0, 1));
      // runs past the frame end wrap into a new frame
      if (f % 3 == 0) for (int k = 0; k < 2 * w; k++) send_word($urandom(), 1'b0);
      drain();
    end
  endtask

  // Larger scale: corners reach further back in the line store.
  task automatic test_extreme_size();
    set_frame(3, 14, 13, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
    send_frame(14, 13, 3);
    drain();
  endtask

  // Full rate at the end: no gaps on either side.
  task automatic test_full_rate();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    set_frame(1, 8, 8, 1864135, 1048576);
    send_frame(8, 8, 1);
    drain();
  endtask

  // Sink: random stall bursts, ready sampled at the clock edge.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (sink_idle_on && stall == 0 && $urandom_range(0, 6) == 0)
        stall = $urandom_range(1, 10);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else
        m_tready <= 1'b1;
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    pix_result_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0)
          report("unexpected response", m_tdata[31:0], 0);
        else begin
          e = expected_q.pop_front();
          if (m_tdata[24:0] !== e.resp) report("response", m_tdata[24:0], e.resp);
          if (m_tdata[34:25] !== e.px) report("pixel_x", m_tdata[34:25], e.px);
          if (m_tdata[44:35] !== e.py) report("pixel_y", m_tdata[44:35], e.py);
          if (m_tlast !== e.last) report("last_of_frame", m_tlast, e.last);
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles <= 0;
      else if (expected_q.size() != 0 || s_tvalid) quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    col_pos = 0;
    row_pos = 0;
    scale_reg = 1;
    inner_w_reg = 1864135;
    outer_w_reg = 1048576;
    width_reg = 640;
    height_reg = 480;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_small_image();
    test_random_frames();
    test_extreme_size();
    test_full_rate();
    if (errors == 0 && expected_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
rtl/bcsr_pkg.sv
rtl/bcsr_ram.sv
rtl/bcsr_math.sv
rtl/box_center_surround_response.sv
verif/box_center_surround_response_tb.sv
